FILE: src/hbsd_pkg.sv
// Shared types, constants and the FCS-16 byte update for the HDLC deframer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package hbsd_pkg;

    localparam int RX_BUFFER_BYTES = 128;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] frame_length;
    } res_t;

    function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ FCS_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/hdlc_byte_stuffing_deframer.sv
// Top level of the HDLC byte-stuffing deframer with FCS-16 check.
// Instantiates hbsd_front, hbsd_queue and hbsd_back; uses hbsd_pkg.
//
// Input stream: one raw serial byte per item on s_tdata. Output stream: one
// result item per payload byte and one per frame end. m_tuser carries the
// kind (data, frame good, frame bad, overflow abort); m_tdata carries the
// unescaped data byte in bits 7:0 and the frame length in bits 15:8.
// Flags, escape bytes and the two trailing FCS bytes produce no data item.
// Throughput: one input item per cycle, sustained, while m_tready is high;
// the front updates escape, FCS-16 and hold combinationally for each byte.
// A result is pushed into the queue when its input item is accepted, then
// moves from the queue into the output register that drives m_tvalid.
// When the receiver stalls, the output register and the two-entry queue fill
// and s_tready drops; no item is lost. Reset clears the frame state and the
// queue, leaving the block idle as if a flag had just been seen.
`default_nettype none

module hdlc_byte_stuffing_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data_byte, [15:8] frame_length
    output logic [1:0]       m_tuser    // [1:0] kind
);

    hbsd_pkg::res_t front_res;
    hbsd_pkg::res_t head_res;
    logic           front_valid;
    logic           q_full;
    logic           q_head_valid;
    logic           q_pop;

    assign s_tready = !q_full;

    hbsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_take   (s_tready),
        .res       (front_res),
        .res_valid (front_valid)
    );

    hbsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_res   (front_res),
        .full       (q_full),
        .pop        (q_pop),
        .head_res   (head_res),
        .head_valid (q_head_valid)
    );

    hbsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_res   (head_res),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_user   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: src/hbsd_front.sv
// Front part of the deframer: accepts raw bytes, tracks flags and escapes,
// runs the FCS-16 and the two-byte hold, and emits classified result items.
// Depends on hbsd_pkg.
`default_nettype none

module hbsd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_take,
    output hbsd_pkg::res_t     res,
    output logic               res_valid
);

    logic        receiving_reg, receiving_next;
    logic        last_flag_reg, last_flag_next;
    logic        esc_reg, esc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] hold_reg, hold_next;
    logic [1:0]  hold_cnt_reg, hold_cnt_next;

    logic        accept;
    logic        is_flag;
    logic        start;
    logic        cont;
    logic        close;
    logic        store;
    logic [7:0]  ub;
    logic [15:0] base_crc;
    logic [7:0]  base_count;
    logic [1:0]  base_hold_cnt;
    logic [15:0] base_hold;
    logic        got;

    assign accept  = in_valid && in_take;
    assign is_flag = (in_byte == hbsd_pkg::FLAG_BYTE);
    assign start   = !receiving_reg && last_flag_reg && !is_flag;
    assign cont    = receiving_reg && !is_flag;
    assign close   = receiving_reg && is_flag;
    assign store   = (start || cont) && (in_byte != hbsd_pkg::ESC_BYTE);
    assign ub      = esc_reg ? (in_byte ^ hbsd_pkg::ESC_XOR) : in_byte;

    assign base_crc      = start ? hbsd_pkg::FCS_INIT : crc_reg;
    assign base_count    = start ? 8'd0 : count_reg;
    assign base_hold_cnt = start ? 2'd0 : hold_cnt_reg;
    assign base_hold     = start ? 16'h0000 : hold_reg;
    assign got           = store && (base_hold_cnt == 2'd2);

    always_comb
    begin
        receiving_next = receiving_reg;
        last_flag_next = last_flag_reg;
        esc_next       = esc_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        hold_next      = hold_reg;
        hold_cnt_next  = hold_cnt_reg;
        res_valid      = 1'b0;
        res.kind         = hbsd_pkg::KIND_DATA;
        res.data_byte    = 8'h00;
        res.frame_length = 8'h00;

        if (accept)
        begin
            last_flag_next = is_flag;
            if (start || cont)
            begin
                receiving_next = 1'b1;
                crc_next       = base_crc;
                count_next     = base_count;
                hold_next      = base_hold;
                hold_cnt_next  = base_hold_cnt;
                if (!store)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next      = 1'b0;
                    count_next    = base_count + 8'd1;
                    crc_next      = hbsd_pkg::fcs_update(base_crc, ub);
                    hold_next     = {base_hold[7:0], ub};
                    hold_cnt_next = (base_hold_cnt == 2'd2) ? 2'd2 : base_hold_cnt + 2'd1;
                end

                if (cont && (count_next >= 8'(hbsd_pkg::RX_BUFFER_BYTES)))
                begin
                    receiving_next = 1'b0;
                    count_next     = 8'd0;
                    hold_cnt_next  = 2'd0;
                    res_valid      = 1'b1;
                    res.kind       = hbsd_pkg::KIND_ABORT;
                end
                else if (got)
                begin
                    res_valid     = 1'b1;
                    res.kind      = hbsd_pkg::KIND_DATA;
                    res.data_byte = base_hold[15:8];
                end
            end
            else if (close)
            begin
                res_valid      = 1'b1;
                receiving_next = 1'b0;
                count_next     = 8'd0;
                hold_cnt_next  = 2'd0;
                if ((crc_reg == hbsd_pkg::FCS_GOOD) && (count_reg >= 8'd3))
                begin
                    res.kind         = hbsd_pkg::KIND_GOOD;
                    res.frame_length = count_reg - 8'd2;
                end
                else
                begin
                    res.kind = hbsd_pkg::KIND_BAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            last_flag_reg <= 1'b1;
            esc_reg       <= 1'b0;
            crc_reg       <= hbsd_pkg::FCS_INIT;
            count_reg     <= 8'd0;
            hold_reg      <= 16'h0000;
            hold_cnt_reg  <= 2'd0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            last_flag_reg <= last_flag_next;
            esc_reg       <= esc_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            hold_reg      <= hold_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hbsd_queue.sv
// Two-entry result queue between the front and back parts of the deframer.
// Depends on hbsd_pkg for the result item type.
`default_nettype none

module hbsd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  var hbsd_pkg::res_t  push_res,
    output logic                full,
    input  wire logic           pop,
    output hbsd_pkg::res_t      head_res,
    output logic                head_valid
);

    hbsd_pkg::res_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_res   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hbsd_back.sv
// Back part of the deframer: pulls result items from the queue, packs them
// into the output stream format and holds them in the output register.
// Depends on hbsd_pkg.
`default_nettype none

module hbsd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  var hbsd_pkg::res_t head_res,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        out_data,
    output logic [1:0]         out_user
);

    logic        valid_reg, valid_next;
    logic [15:0] data_reg, data_next;
    logic [1:0]  user_reg, user_next;
    logic        load;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = {head_res.frame_length, head_res.data_byte};
            user_next  = head_res.kind;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

`default_nettype wire

FILE: tb/hbsd_checker.sv
`timescale 1ns / 100ps
// Result checker for hdlc_byte_stuffing_deframer: watches the input and output
// streams, predicts frame results per accepted item and compares them in order.
// Depends on hbsd_pkg for the byte constants, kind_t and res_t.
module hbsd_checker
    import hbsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               fail_count,
    output int               pending
);

    bit          in_frame;
    bit          after_flag;
    bit          esc_armed;
    logic [15:0] fcs_acc;
    logic [7:0]  stored_cnt;
    logic [15:0] hold_pair;
    int          hold_fill;
    int          errors;
    res_t        frame_results_q[$];

    function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            c = {1'b0, c[15:1]} ^ ((c[0] ^ b[k]) ? FCS_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic push_result(input kind_t k, input logic [7:0] d, input logic [7:0] len);
        res_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.frame_length = len;
        frame_results_q.push_back(r);
    endtask

    task automatic take_byte(input logic [7:0] raw, output bit emitted,
                             output logic [7:0] out_byte);
        logic [7:0] b;
        b        = raw;
        emitted  = 1'b0;
        out_byte = 8'h00;
        if (raw == ESC_BYTE)
        begin
            esc_armed = 1'b1;
        end
        else
        begin
            if (esc_armed)
            begin
                b         = raw ^ ESC_XOR;
                esc_armed = 1'b0;
            end
            stored_cnt = stored_cnt + 8'd1;
            fcs_acc    = crc16_shift(fcs_acc, b);
            if (hold_fill == 2)
            begin
                emitted  = 1'b1;
                out_byte = hold_pair[15:8];
            end
            hold_pair = {hold_pair[7:0], b};
            if (hold_fill < 2)
                hold_fill++;
        end
    endtask

    task automatic predict_frame_result(input logic [7:0] raw);
        bit         flag;
        bit         got;
        logic [7:0] emit;
        flag = (raw == FLAG_BYTE);
        if (!in_frame && after_flag && !flag)
        begin
            in_frame   = 1'b1;
            stored_cnt = 8'd0;
            fcs_acc    = FCS_INIT;
            hold_pair  = 16'h0000;
            hold_fill  = 0;
            take_byte(raw, got, emit);
            if (got)
                push_result(KIND_DATA, emit, 8'd0);
        end
        else if (in_frame && !flag)
        begin
            take_byte(raw, got, emit);
            if (int'(stored_cnt) + 1 > RX_BUFFER_BYTES)
            begin
                in_frame   = 1'b0;
                stored_cnt = 8'd0;
                hold_fill  = 0;
                push_result(KIND_ABORT, 8'd0, 8'd0);
            end
            else if (got)
            begin
                push_result(KIND_DATA, emit, 8'd0);
            end
        end
        else if (in_frame)
        begin
            if (fcs_acc == FCS_GOOD && stored_cnt >= 8'd3)
                push_result(KIND_GOOD, 8'd0, stored_cnt - 8'd2);
            else
                push_result(KIND_BAD, 8'd0, 8'd0);
            in_frame   = 1'b0;
            stored_cnt = 8'd0;
            hold_fill  = 0;
        end
        after_flag = flag;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            in_frame   = 1'b0;
            after_flag = 1'b1;
            esc_armed  = 1'b0;
            fcs_acc    = FCS_INIT;
            stored_cnt = 8'd0;
            hold_pair  = 16'h0000;
            hold_fill  = 0;
            frame_results_q.delete();
            pending    <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_frame_result(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d data %02h length %0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[15:8]);
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("frame_length", want.frame_length, m_tdata[15:8]);
                end
            end
            pending    <= frame_results_q.size();
            fail_count <= errors;
        end
    end

endmodule

FILE: tb/tb_hdlc_byte_stuffing_deframer.sv
`timescale 1ns / 100ps
// Top of the testbench for hdlc_byte_stuffing_deframer: clock, reset, framed byte
// stimulus with sender and receiver stalls, and the verdict.
// Depends on hbsd_pkg, hbsd_checker and the deframer RTL.
module tb_hdlc_byte_stuffing_deframer;
    import hbsd_pkg::*;

    localparam int ITEMS_TOTAL = 1450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;

    int          tx_idle_pct = 23;
    int          rx_idle_pct = 48;
    int          holdoff_cnt = 0;
    int          items_sent = 0;
    logic [7:0]  last_sent = FLAG_BYTE;
    logic [7:0]  frame_payload[$];

    hdlc_byte_stuffing_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hbsd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0: return 8'h00;
            1: return 8'hFF;
            2: return FLAG_BYTE;
            3: return ESC_BYTE;
            4: return FLAG_BYTE ^ ESC_XOR;
            5: return ESC_BYTE ^ ESC_XOR;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        last_sent = b;
    endtask

    // Append the FCS, stuff the frame and close it with a flag.
    task automatic send_frame(input bit corrupt);
        logic [15:0] c;
        logic [7:0]  raw[$];
        logic [7:0]  b;
        int          idx;
        c = FCS_INIT;
        foreach (frame_payload[i])
            c = fcs_next(c, frame_payload[i]);
        c   = ~c;
        raw = frame_payload;
        raw.push_back(c[7:0]);
        raw.push_back(c[15:8]);
        if (corrupt)
        begin
            idx      = $urandom_range(raw.size() - 1);
            raw[idx] = raw[idx] ^ (8'h01 << $urandom_range(7));
        end
        if (last_sent != FLAG_BYTE)
            send(FLAG_BYTE);
        foreach (raw[i])
        begin
            b = raw[i];
            if (b == FLAG_BYTE || b == ESC_BYTE ||
                ((b ^ ESC_XOR) != FLAG_BYTE && (b ^ ESC_XOR) != ESC_BYTE &&
                 $urandom_range(15) == 0))
            begin
                send(ESC_BYTE);
                send(b ^ ESC_XOR);
            end
            else
            begin
                send(b);
            end
        end
        send(FLAG_BYTE);
    endtask

    task automatic fill_payload(input int len);
        frame_payload.delete();
        repeat (len)
            frame_payload.push_back(pick_byte());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_cnt > 0)
            begin
                holdoff_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        int phase;
        int sel;
        int r;
        phase = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(FLAG_BYTE);
        send(FLAG_BYTE);
        frame_payload = {FLAG_BYTE};
        send_frame(1'b0);
        frame_payload = {8'h00, 8'hFF};
        send_frame(1'b0);
        send(8'h00);
        send(8'h00);
        send(FLAG_BYTE);
        send(8'h11);
        send(8'h22);
        send(FLAG_BYTE);
        send(8'h33);
        send(ESC_BYTE);
        send(FLAG_BYTE);
        send(8'h41);
        send(8'h62);
        send(FLAG_BYTE);
        send(FLAG_BYTE);

        fill_payload(126 + $urandom_range(4));
        send_frame(1'b0);
        repeat (4) send(pick_byte());

        while (items_sent < ITEMS_TOTAL)
        begin
            if (phase == 0 && items_sent > ITEMS_TOTAL / 3)
            begin
                wait_drained();
                tx_idle_pct = 48;
                rx_idle_pct = 23;
                phase = 1;
            end
            if (phase == 1 && items_sent > 2 * ITEMS_TOTAL / 3)
            begin
                wait_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                holdoff_cnt = 300;
                phase = 2;
            end
            sel = $urandom_range(99);
            if (sel < 88)
            begin
                r = $urandom_range(99);
                if (r < 2)
                    fill_payload(124 + $urandom_range(11));
                else if (r < 15)
                    fill_payload(13 + $urandom_range(47));
                else
                    fill_payload($urandom_range(12));
                send_frame(sel >= 78);
            end
            else if (sel < 94)
            begin
                repeat ($urandom_range(1, 6)) send(pick_byte());
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send(FLAG_BYTE);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/hbsd_pkg.sv
src/hbsd_front.sv
src/hbsd_queue.sv
src/hbsd_back.sv
src/hdlc_byte_stuffing_deframer.sv
tb/hbsd_checker.sv
tb/tb_hdlc_byte_stuffing_deframer.sv
